// ===== rtl/mpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants of the multichannel PWM generator: transaction
// payloads, action and register codes, reset values and channel command types.
// ----------------------------------------------------------------------------
package mpwm_pkg;

   localparam int REQ_TICK_WIDTH   = 24;
   localparam int CSR_DATA_WIDTH   = 24;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int FIELD_CHANNELS   = 8;

   // Actions carried by a request
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_DISABLE = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] PERIOD_RESET = 24'd20000;
   localparam logic [CSR_DATA_WIDTH-1:0] TOL_RESET    = 24'd10;

   typedef struct packed {
      logic [1:0]                action;
      logic [2:0]                channel;
      logic [REQ_TICK_WIDTH-1:0] high_ticks;
   } mpwm_req_type;

   typedef struct packed {
      logic [FIELD_CHANNELS-1:0] pin_levels;
      logic [FIELD_CHANNELS-1:0] running_mask;
   } mpwm_rsp_type;

   // One command to a channel; at most one bit is set
   typedef struct packed {
      logic tick;
      logic load;
      logic halt;
   } mpwm_cmd_type;

   // Channel state after the command
   typedef struct packed {
      logic pin;
      logic running;
   } mpwm_status_type;

endpackage

// ===== rtl/multichannel_pwm_with_tolerance.sv =====
// ----------------------------------------------------------------------------
// multichannel_pwm_with_tolerance
// Multichannel PWM generator with a shared period and a minimum phase length.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one transaction per timer tick, duty update (set) or
//   disable. A set computes the high and low time from the requested high
//   time, the period and the tolerance; too short a high time stops the
//   channel, too short a low time forces full on.
//   rsp_ channel: one transaction per request, carrying every channel's pin
//   level and running bit after that request.
//   csr_ channel: register 0 is the period, register 1 the tolerance. It is
//   always ready; write it only while no request is in flight.
// Pipeline: a request is registered in the plan stage, then the channel update
//   is registered into the result register; one transaction per cycle is
//   sustained while rsp_stall stays low, limited by the channel state update.
// Reset: all channels stopped, pins low, period 20000 and tolerance 10 ticks.
// Stall: a stalled result holds in the output register; the plan stage holds
//   one more request, after which req_stall is raised until rsp_stall drops.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_tolerance #(
   parameter int CHANNELS   = 8,
   parameter int TICK_WIDTH = 24
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  mpwm_pkg::mpwm_req_type                     req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output mpwm_pkg::mpwm_rsp_type                     rsp_data,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [mpwm_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [mpwm_pkg::CSR_DATA_WIDTH-1:0]        csr_data
);
   import mpwm_pkg::*;

   typedef struct packed {
      logic [1:0]            action;
      logic [2:0]            channel;
      logic                  stop;
      logic [TICK_WIDTH-1:0] high;
      logic [TICK_WIDTH-1:0] low;
   } stage_type;

   // Configuration registers
   logic [TICK_WIDTH-1:0] period_ff;
   logic [TICK_WIDTH-1:0] tolerance_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= TICK_WIDTH'(PERIOD_RESET);
         tolerance_ff <= TICK_WIDTH'(TOL_RESET);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PERIOD) begin
            period_ff <= TICK_WIDTH'(csr_data);
         end
         if (csr_index == CSR_TOLERANCE) begin
            tolerance_ff <= TICK_WIDTH'(csr_data);
         end
      end
   end

   // Plan the set: clamp to the period, derive the low time, apply tolerance.
   // Only the request and the configuration feed this, so it runs ahead of the channel state.
   logic [TICK_WIDTH-1:0] req_high;
   logic [TICK_WIDTH-1:0] low_raw;
   logic [TICK_WIDTH-1:0] high_clamp;
   logic [TICK_WIDTH-1:0] low_clamp;
   logic                  below_tol;
   logic                  over_period;
   logic                  short_low;
   stage_type             stage_in;

   always_comb begin
      req_high    = TICK_WIDTH'(req_data.high_ticks);
      below_tol   = (req_high < tolerance_ff);
      over_period = (req_high > period_ff);
      low_raw     = period_ff - req_high;
      high_clamp  = over_period ? period_ff : req_high;
      low_clamp   = over_period ? '0 : low_raw;
      short_low   = (low_clamp < tolerance_ff);

      stage_in.action  = req_data.action;
      stage_in.channel = req_data.channel;
      stage_in.high    = short_low ? period_ff : high_clamp;
      stage_in.low     = short_low ? '0 : low_clamp;
      // a high time that comes out as zero stops the channel too
      stage_in.stop    = below_tol || (stage_in.high == '0);
   end

   // Plan stage and output register handshake
   stage_type stage_ff;
   logic      stage_valid_ff;
   logic      rsp_valid_ff;
   mpwm_rsp_type rsp_data_ff, rsp_data_in;
   logic      out_free;
   logic      advance;
   logic      req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = stage_valid_ff && out_free;
   assign req_stall  = stage_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   // Channels: every channel sees the tick; set and disable hit one channel
   mpwm_status_type status_in [CHANNELS];

   for (genvar c = 0; c < CHANNELS; c++) begin : g_channel
      mpwm_cmd_type cmd;
      logic         hit;

      always_comb begin
         hit      = (32'(stage_ff.channel) == c);
         cmd.tick = 1'b0;
         cmd.load = 1'b0;
         cmd.halt = 1'b0;
         unique case (stage_ff.action)
            ACT_TICK:    cmd.tick = 1'b1;
            ACT_SET: begin
               cmd.load = hit && !stage_ff.stop;
               cmd.halt = hit && stage_ff.stop;
            end
            ACT_DISABLE: cmd.halt = hit;
            default: begin
               // unknown action: leave the channel alone
            end
         endcase
      end

      mpwm_channel #(
         .TICK_WIDTH (TICK_WIDTH)
      ) u_channel (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cmd       (cmd),
         .load_high (stage_ff.high),
         .load_low  (stage_ff.low),
         .period    (period_ff),
         .status_in (status_in[c])
      );
   end

   // Pack the result; lanes past the last channel read as zero
   for (genvar i = 0; i < FIELD_CHANNELS; i++) begin : g_field
      if (i < CHANNELS) begin : g_used
         assign rsp_data_in.pin_levels[i]   = status_in[i].pin;
         assign rsp_data_in.running_mask[i] = status_in[i].running;
      end else begin : g_unused
         assign rsp_data_in.pin_levels[i]   = 1'b0;
         assign rsp_data_in.running_mask[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions
   a_pin_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.pin_levels & ~rsp_data_ff.running_mask) == '0))
      else $error("pin high on a stopped channel");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_free) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("planned transaction lost while the output was stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !stage_valid_ff))
      else $error("transaction present right after reset");

endmodule

// ===== rtl/mpwm_channel.sv =====
// ----------------------------------------------------------------------------
// mpwm_channel
// One PWM channel: high and low times, phase countdown and pin level.
// ----------------------------------------------------------------------------
module mpwm_channel #(
   parameter int TICK_WIDTH = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  mpwm_pkg::mpwm_cmd_type    cmd,
   input  logic [TICK_WIDTH-1:0]     load_high,
   input  logic [TICK_WIDTH-1:0]     load_low,
   input  logic [TICK_WIDTH-1:0]     period,
   output mpwm_pkg::mpwm_status_type status_in
);
   import mpwm_pkg::*;

   localparam logic [TICK_WIDTH-1:0] LOW_RESET = TICK_WIDTH'(PERIOD_RESET);
   localparam logic [TICK_WIDTH-1:0] ONE_TICK  = TICK_WIDTH'(1);

   logic [TICK_WIDTH-1:0] high_ff, high_in;
   logic [TICK_WIDTH-1:0] low_ff, low_in;
   logic [TICK_WIDTH-1:0] countdown_ff, countdown_in;
   logic                  next_high_ff, next_high_in;
   logic                  pin_ff, pin_in;
   logic                  running;

   always_comb begin
      high_in      = high_ff;
      low_in       = low_ff;
      countdown_in = countdown_ff;
      next_high_in = next_high_ff;
      pin_in       = pin_ff;
      running      = (high_ff != '0);
      if (advance) begin
         priority if (cmd.tick && running) begin
            if (countdown_ff <= ONE_TICK) begin
               // phase end
               priority if (next_high_ff) begin
                  pin_in       = 1'b1;
                  countdown_in = high_ff;
                  next_high_in = 1'b0;
               end else if (low_ff != '0) begin
                  pin_in       = 1'b0;
                  countdown_in = low_ff;
                  next_high_in = 1'b1;
               end else begin
                  countdown_in = high_ff;
                  next_high_in = 1'b1;
               end
            end else begin
               countdown_in = countdown_ff - ONE_TICK;
            end
         end else if (cmd.load) begin
            high_in = load_high;
            low_in  = load_low;
            // start a stopped channel with a high phase
            if (!running) begin
               pin_in       = 1'b1;
               countdown_in = load_high;
               next_high_in = 1'b0;
            end
         end else if (cmd.halt && running) begin
            high_in      = '0;
            low_in       = period;
            next_high_in = 1'b1;
            countdown_in = '0;
            pin_in       = 1'b0;
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff      <= '0;
         low_ff       <= LOW_RESET;
         countdown_ff <= '0;
         next_high_ff <= 1'b1;
         pin_ff       <= 1'b0;
      end else begin
         high_ff      <= high_in;
         low_ff       <= low_in;
         countdown_ff <= countdown_in;
         next_high_ff <= next_high_in;
         pin_ff       <= pin_in;
      end
   end

   assign status_in.pin     = pin_in;
   assign status_in.running = (high_in != '0);

endmodule

// ===== bench/tb_multichannel_pwm_with_tolerance.sv =====
// ----------------------------------------------------------------------------
// tb_multichannel_pwm_with_tolerance
// Self-checking bench for the multichannel PWM generator. A clocked driver
// feeds request transactions from a queue, a duty-cycle predictor computes
// each channel's pin and running bits, and a clocked monitor compares every
// result transaction with the oldest prediction. Several period and tolerance
// settings are run with varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_multichannel_pwm_with_tolerance;

   import mpwm_pkg::*;

   localparam int          NUM_CH      = 8;
   localparam int          TICK_W      = REQ_TICK_WIDTH;
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;
   localparam int          NUM_PHASES  = 6;
   localparam int          RANDOM_REQS = 75;
   localparam int          HOLD_CYCLES = 48;
   localparam int          LIMIT_TIME  = 20 * 400000;

   // DUT ports; every input starts at a known value
   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_valid  = 1'b0;
   logic          req_stall;
   mpwm_req_type  req_data   = '0;
   logic          rsp_valid;
   logic          rsp_stall  = 1'b0;
   mpwm_rsp_type  rsp_data;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   // Duty-cycle predictor state: the settings and one entry per channel
   logic [TICK_W-1:0] cfg_period;
   logic [TICK_W-1:0] cfg_tolerance;
   logic [TICK_W-1:0] ch_high      [NUM_CH];
   logic [TICK_W-1:0] ch_low       [NUM_CH];
   logic              ch_next_high [NUM_CH];
   logic [TICK_W-1:0] ch_count     [NUM_CH];
   logic              ch_pin       [NUM_CH];

   // Pending requests and predicted levels
   mpwm_req_type pending_req[$];
   mpwm_rsp_type expected_levels[$];

   // Traffic shaping, set per phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_request   = 1'b0;
   logic        hold_seen      = 1'b0;
   int unsigned hold_left      = 0;

   // Bookkeeping
   int unsigned error_count     = 0;
   int unsigned results_checked = 0;
   int unsigned settings_count  = 0;
   int unsigned input_held      = 0;
   int unsigned act_count [4]   = '{default: 0};

   multichannel_pwm_with_tolerance #(
      .CHANNELS   (NUM_CH),
      .TICK_WIDTH (TICK_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Start the next phase of a running channel
   function automatic void begin_next_phase(input int c);
      if (ch_next_high[c]) begin
         ch_pin[c]       = 1'b1;
         ch_count[c]     = ch_high[c];
         ch_next_high[c] = 1'b0;
      end else if (ch_low[c] != '0) begin
         ch_pin[c]       = 1'b0;
         ch_count[c]     = ch_low[c];
         ch_next_high[c] = 1'b1;
      end else begin
         // zero low time: stay high, reload the high phase
         ch_count[c]     = ch_high[c];
         ch_next_high[c] = 1'b1;
      end
   endfunction

   // Stop a channel and drive its pin low; a stopped channel is left alone
   function automatic void halt_channel(input int c);
      if (ch_high[c] != '0) begin
         ch_high[c]      = '0;
         ch_low[c]       = cfg_period;
         ch_next_high[c] = 1'b1;
         ch_count[c]     = '0;
         ch_pin[c]       = 1'b0;
      end
   endfunction

   // Apply one request to the predictor and return the levels it leaves
   function automatic mpwm_rsp_type apply_request(input mpwm_req_type r);
      mpwm_rsp_type      levels;
      logic [TICK_W-1:0] hi;
      logic [TICK_W-1:0] lo;
      logic              was_stopped;
      int                c;
      c = int'(r.channel);
      case (r.action)
         ACT_TICK: begin
            for (int k = 0; k < NUM_CH; k++) begin
               if (ch_high[k] != '0) begin
                  if (ch_count[k] <= 1)
                     begin_next_phase(k);
                  else
                     ch_count[k] = ch_count[k] - 1'b1;
               end
            end
         end
         ACT_SET: begin
            hi = r.high_ticks;
            if (hi < cfg_tolerance) begin
               halt_channel(c);
            end else begin
               if (hi > cfg_period)
                  hi = cfg_period;
               lo = cfg_period - hi;
               // too short a low phase forces full on
               if (lo < cfg_tolerance) begin
                  hi = cfg_period;
                  lo = '0;
               end
               if (hi == '0) begin
                  halt_channel(c);
               end else begin
                  was_stopped = (ch_high[c] == '0);
                  ch_high[c]  = hi;
                  ch_low[c]   = lo;
                  // a stopped channel starts at once with a high phase;
                  // a running one picks up the new times at its next phase end
                  if (was_stopped) begin
                     ch_next_high[c] = 1'b1;
                     begin_next_phase(c);
                  end
               end
            end
         end
         ACT_DISABLE: halt_channel(c);
         default: ;
      endcase
      for (int k = 0; k < NUM_CH; k++) begin
         levels.pin_levels[k]   = ch_pin[k];
         levels.running_mask[k] = (ch_high[k] != '0);
      end
      return levels;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offer queued requests, predict each accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_levels.push_back(apply_request(req_data));
            act_count[req_data.action]++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transaction as it is
            input_held++;
         end else if (pending_req.size() != 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_req.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each accepted result, drive the receiver stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_proc
      mpwm_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: result with nothing expected: pins %h running %h",
                        $time, rsp_data.pin_levels, rsp_data.running_mask);
               error_count++;
            end else begin
               want = expected_levels.pop_front();
               results_checked++;
               if (rsp_data.pin_levels !== want.pin_levels) begin
                  $display("%0t: pin_levels mismatch, expected %h actual %h",
                           $time, want.pin_levels, rsp_data.pin_levels);
                  error_count++;
               end
               if (rsp_data.running_mask !== want.running_mask) begin
                  $display("%0t: running_mask mismatch, expected %h actual %h",
                           $time, want.running_mask, rsp_data.running_mask);
                  error_count++;
               end
            end
         end
         // a toggle of hold_request starts one long hold-off
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_request(input logic [1:0] action, input int channel,
                               input logic [TICK_W-1:0] ticks);
      mpwm_req_type r;
      r.action     = action;
      r.channel    = 3'(channel);
      r.high_ticks = ticks;
      pending_req.push_back(r);
   endtask

   // Mostly ticks so that phases play out, with most sets up to just past the period
   task automatic push_random_requests(input int count);
      mpwm_req_type r;
      int unsigned  pick;
      int unsigned  span;
      for (int n = 0; n < count; n++) begin
         pick         = $urandom_range(0, 99);
         r.channel    = 3'($urandom_range(0, NUM_CH - 1));
         r.high_ticks = TICK_W'($urandom);
         if (pick < 68)
            r.action = ACT_TICK;
         else if (pick < 88)
            r.action = ACT_SET;
         else if (pick < 96)
            r.action = ACT_DISABLE;
         else
            r.action = ACT_UNUSED;
         if (r.action == ACT_SET && $urandom_range(0, 3) != 0) begin
            span         = 32'(cfg_period);
            r.high_ticks = TICK_W'($urandom_range(0, span + 2));
         end
         pending_req.push_back(r);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PERIOD)
         cfg_period = value;
      else if (idx == CSR_TOLERANCE)
         cfg_tolerance = value;
      settings_count++;
      @(negedge clock);
   endtask

   // Wait until nothing is queued, offered or expected, then let the
   // pipeline settle
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_valid || expected_levels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_proc
      logic [TICK_W-1:0] phase_period [NUM_PHASES];
      logic [TICK_W-1:0] phase_tol    [NUM_PHASES];
      int unsigned       phase_idle   [NUM_PHASES];
      int unsigned       phase_stall  [NUM_PHASES];

      phase_period = '{24'd6,  24'd1,  24'hFFFFFF, 24'd13, 24'hFFFFFF, 24'd9};
      phase_tol    = '{24'd2,  24'd0,  24'hFFFFFF, 24'd0,  24'd0,      24'd3};
      phase_idle   = '{64,     0,      17,         0,      17,         0};
      phase_stall  = '{0,      64,     17,         0,      17,         0};

      // Predictor starts in the reset state
      cfg_period    = PERIOD_RESET;
      cfg_tolerance = TOL_RESET;
      for (int k = 0; k < NUM_CH; k++) begin
         ch_high[k]      = '0;
         ch_low[k]       = PERIOD_RESET;
         ch_next_high[k] = 1'b1;
         ch_count[k]     = '0;
         ch_pin[k]       = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset period and tolerance
      push_request(ACT_TICK,    0, 24'hFFFFFF);   // tick with all channels stopped
      push_request(ACT_SET,     0, 24'd0);        // stop on a stopped channel
      push_request(ACT_SET,     1, 24'd9);        // just below the tolerance
      push_request(ACT_DISABLE, 2, 24'd0);        // disable a stopped channel
      push_request(ACT_UNUSED,  3, 24'd0);        // unused action
      push_request(ACT_SET,     0, 24'd10);       // exactly the tolerance
      push_request(ACT_SET,     1, 24'hFFFFFF);   // clamp to period, full on
      push_request(ACT_SET,     2, 24'd19990);    // low time equal to tolerance
      push_request(ACT_SET,     3, 24'd19991);    // low time short, full on
      push_request(ACT_SET,     7, 24'd20000);    // whole period, zero low time
      for (int n = 0; n < 10; n++)
         push_request(ACT_TICK, n, 24'd0);        // run channel 0 into its low phase
      push_request(ACT_SET,     0, 24'd5);        // stopping set on a running channel
      push_request(ACT_SET,     2, 24'd500);      // retime a running channel
      push_request(ACT_DISABLE, 7, 24'd0);
      push_request(ACT_DISABLE, 7, 24'd0);        // second disable changes nothing
      push_request(ACT_UNUSED,  5, 24'hFFFFFF);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_until_drained();
         write_register(CSR_PERIOD,    phase_period[p]);
         write_register(CSR_TOLERANCE, phase_tol[p]);
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         if (p == 3) begin
            // Stall results for a long stretch while requests keep coming,
            // then hold the sender back until every result is in
            push_random_requests(RANDOM_REQS / 2);
            hold_request = ~hold_request;
            wait_until_drained();
            push_random_requests(RANDOM_REQS - RANDOM_REQS / 2);
         end else begin
            push_random_requests(RANDOM_REQS);
         end
      end

      wait_until_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d ticks, %0d sets, %0d disables, %0d unused actions",
               act_count[ACT_TICK], act_count[ACT_SET], act_count[ACT_DISABLE],
               act_count[ACT_UNUSED]);
      $display("over %0d register writes; %0d results compared, input held %0d cycles",
               settings_count, results_checked, input_held);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Stop a hung run
   initial begin : limit_proc
      #(LIMIT_TIME);
      $display("%0t: run did not finish in time", $time);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mpwm_pkg.sv
rtl/mpwm_channel.sv
rtl/multichannel_pwm_with_tolerance.sv
bench/tb_multichannel_pwm_with_tolerance.sv
